@@ hw/rtl/polynomial_add_multiply_defines.svh @@
// ---------------------------------------------------------------------------
// Polynomial add/multiply assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef POLYNOMIAL_ADD_MULTIPLY_DEFINES_SVH
`define POLYNOMIAL_ADD_MULTIPLY_DEFINES_SVH

// same-cycle implication
`define PAM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PAM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/pam_pkg.sv @@
// ---------------------------------------------------------------------------
// Polynomial add/multiply package
// Field widths, codes and the control bundle driven into the cell chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pam_pkg;

	localparam int EXP_IN_W   = 4;
	localparam int EXP_OUT_W  = 5;
	localparam int OUT_COEF_W = 32;

	localparam logic KIND_SUM  = 1'b0;
	localparam logic KIND_PROD = 1'b1;

	localparam logic SEL_A = 1'b0;
	localparam logic SEL_B = 1'b1;

	// per-cycle commands broadcast to every cell
	typedef struct packed {
		logic                load;
		logic                sel;
		logic [EXP_IN_W-1:0] exp;
		logic                rot_ab;
		logic                rot_b;
		logic                clr_pipe;
		logic                mac;
		logic                clr_store;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/pam_cell.sv @@
// ---------------------------------------------------------------------------
// Polynomial add/multiply cell
// Holds the A and B coefficient slots and presence bits of one exponent,
// shifts them to the next cell on rotation, and runs one tap of the
// transposed convolution chain for the product.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pam_cell import pam_pkg::*; #(
	parameter int COEF_WIDTH = 32,
	parameter int IDX        = 0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire cell_ctrl_t      ctrl,
	input  wire [COEF_WIDTH-1:0] load_coef,
	input  wire [COEF_WIDTH-1:0] x_coef,
	input  wire                  x_pres,
	input  wire [COEF_WIDTH-1:0] prev_a,
	input  wire [COEF_WIDTH-1:0] prev_b,
	input  wire                  prev_pa,
	input  wire                  prev_pb,
	input  wire [COEF_WIDTH-1:0] prev_r,
	input  wire                  prev_rp,
	output logic [COEF_WIDTH-1:0] a,
	output logic [COEF_WIDTH-1:0] b,
	output logic                  pa,
	output logic                  pb,
	output logic [COEF_WIDTH-1:0] r,
	output logic                  rp
);

	logic [COEF_WIDTH-1:0] a_q, b_q, acc_q;
	logic                  pa_q, pb_q, pres_s1, rp_q;
	logic [COEF_WIDTH-1:0] prod_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q  <= '0;
			b_q  <= '0;
			pa_q <= 1'b0;
			pb_q <= 1'b0;
		end else if (ctrl.clr_store) begin
			a_q  <= '0;
			b_q  <= '0;
			pa_q <= 1'b0;
			pb_q <= 1'b0;
		end else if (ctrl.load && ctrl.exp == EXP_IN_W'(IDX)) begin
			if (ctrl.sel == SEL_B) begin
				b_q  <= b_q + load_coef;
				pb_q <= 1'b1;
			end else begin
				a_q  <= a_q + load_coef;
				pa_q <= 1'b1;
			end
		end else if (ctrl.rot_ab) begin
			a_q  <= prev_a;
			b_q  <= prev_b;
			pa_q <= prev_pa;
			pb_q <= prev_pb;
		end else if (ctrl.rot_b) begin
			b_q  <= prev_b;
			pb_q <= prev_pb;
		end
	end

	// stage 1: partial products of a * x, wrapped to COEF_WIDTH
	if (COEF_WIDTH <= 32) begin : g_mul_narrow
		logic [COEF_WIDTH-1:0] pp_s1;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pp_s1 <= '0;
			end else if (ctrl.clr_pipe) begin
				pp_s1 <= '0;
			end else if (ctrl.mac) begin
				pp_s1 <= a_q * x_coef;
			end
		end

		assign prod_w = pp_s1;
	end else begin : g_mul_wide
		localparam int HW = COEF_WIDTH - 32;
		logic [63:0]   ll_s1;
		logic [HW-1:0] cross_s1;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ll_s1    <= '0;
				cross_s1 <= '0;
			end else if (ctrl.clr_pipe) begin
				ll_s1    <= '0;
				cross_s1 <= '0;
			end else if (ctrl.mac) begin
				ll_s1    <= 64'(a_q[31:0]) * 64'(x_coef[31:0]);
				cross_s1 <= HW'(a_q[31:0]) * x_coef[COEF_WIDTH-1:32]
					+ a_q[COEF_WIDTH-1:32] * HW'(x_coef[31:0]);
			end
		end

		// cross terms only reach bit 32 and above, so their low HW bits suffice
		assign prod_w = COEF_WIDTH'(ll_s1) + {cross_s1, 32'b0};
	end

	// stage 2: add to the partial sum handed up from the cell below
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pres_s1 <= 1'b0;
			acc_q   <= '0;
			rp_q    <= 1'b0;
		end else if (ctrl.clr_pipe) begin
			pres_s1 <= 1'b0;
			acc_q   <= '0;
			rp_q    <= 1'b0;
		end else if (ctrl.mac) begin
			pres_s1 <= pa_q & x_pres;
			acc_q   <= prod_w + prev_r;
			rp_q    <= pres_s1 | prev_rp;
		end
	end

	assign a  = a_q;
	assign b  = b_q;
	assign pa = pa_q;
	assign pb = pb_q;
	assign r  = acc_q;
	assign rp = rp_q;

endmodule

`default_nettype wire

@@ hw/rtl/polynomial_add_multiply.sv @@
// ---------------------------------------------------------------------------
// Polynomial adder and multiplier
// Loads A and B term by term, then streams the sum and the product terms,
// highest exponent first, from a row of per-exponent cells.
// ---------------------------------------------------------------------------
// A term transaction is taken when term_valid and term_ready are both high.
// The transaction with last_term set starts the job, and the block holds
// term_ready low until the job ends, pausing while results stall. With
// L = min(MAX_TERMS, 16) cells, it rotates the cell row past the top cell to
// form the sum terms, steps the systolic multiply-accumulate chain (two
// register stages) to form the product terms, and then releases the final
// result and clears the stores. Results leave through an output register
// with one term held back, so run_end marks the true last term.
`timescale 1ns / 1ps
`default_nettype none
`include "polynomial_add_multiply_defines.svh"

module polynomial_add_multiply import pam_pkg::*; #(
	parameter int MAX_TERMS  = 16,
	parameter int COEF_WIDTH = 32
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         term_valid,
	output logic                        term_ready,
	input  wire                         operand_sel,
	input  wire signed [31:0]           term_coef,
	input  wire [EXP_IN_W-1:0]          term_exp,
	input  wire                         last_term,
	output logic                        result_valid,
	input  wire                         result_ready,
	output logic                        result_kind,
	output logic signed [OUT_COEF_W-1:0] out_coef,
	output logic [EXP_OUT_W-1:0]        out_exp,
	output logic                        run_end
);

	localparam int L     = (MAX_TERMS < 16) ? MAX_TERMS : 16;
	localparam int W     = COEF_WIDTH;
	localparam int CNT_W = $clog2(2 * L + 1);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SUM,
		ST_PROD,
		ST_FLUSH
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 hold_valid_q, result_valid_q;
	logic                 hold_kind_q, kind_q, run_end_q;
	logic [W-1:0]         hold_coef_q;
	logic [EXP_OUT_W-1:0] hold_exp_q, exp_q;
	logic [OUT_COEF_W-1:0] coef_q;

	logic accept, adv, step;
	cell_ctrl_t ctrl;

	logic [W-1:0] a_w [L];
	logic [W-1:0] b_w [L];
	logic [W-1:0] r_w [L];
	logic         pa_w [L];
	logic         pb_w [L];
	logic         rp_w [L];

	logic [W-1:0]         load_coef, x_coef, sum_w;
	logic                 x_pres;
	logic                 cand_valid, cand_kind;
	logic [W-1:0]         cand_coef;
	logic [EXP_OUT_W-1:0] cand_exp;
	logic                 emit_hold, emit_last;

	assign term_ready = (state_q == ST_LOAD);
	assign accept     = term_valid && term_ready;
	assign adv        = !result_valid_q || result_ready;
	assign step       = adv && (state_q != ST_LOAD);
	assign load_coef  = W'(term_coef);

	always_comb begin
		ctrl           = '0;
		ctrl.load      = accept;
		ctrl.sel       = operand_sel;
		ctrl.exp       = term_exp;
		ctrl.rot_ab    = step && (state_q == ST_SUM);
		ctrl.clr_pipe  = step && (state_q == ST_SUM);
		ctrl.rot_b     = step && (state_q == ST_PROD);
		ctrl.mac       = step && (state_q == ST_PROD);
		ctrl.clr_store = step && (state_q == ST_FLUSH);
	end

	// B leaves the top cell highest exponent first; zeros once it is spent
	assign x_coef = (state_q == ST_PROD && cnt_q < CNT_W'(L)) ? b_w[L-1] : '0;
	assign x_pres = (state_q == ST_PROD && cnt_q < CNT_W'(L)) && pb_w[L-1];

	for (genvar e = 0; e < L; e++) begin : g_cell
		logic [W-1:0] p_a, p_b, p_r;
		logic         p_pa, p_pb, p_rp;

		if (e == 0) begin : g_bottom
			assign p_a  = a_w[L-1];
			assign p_b  = b_w[L-1];
			assign p_pa = pa_w[L-1];
			assign p_pb = pb_w[L-1];
			assign p_r  = '0;
			assign p_rp = 1'b0;
		end else begin : g_inner
			assign p_a  = a_w[e-1];
			assign p_b  = b_w[e-1];
			assign p_pa = pa_w[e-1];
			assign p_pb = pb_w[e-1];
			assign p_r  = r_w[e-1];
			assign p_rp = rp_w[e-1];
		end

		pam_cell #(
			.COEF_WIDTH(W),
			.IDX       (e)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.load_coef(load_coef),
			.x_coef   (x_coef),
			.x_pres   (x_pres),
			.prev_a   (p_a),
			.prev_b   (p_b),
			.prev_pa  (p_pa),
			.prev_pb  (p_pb),
			.prev_r   (p_r),
			.prev_rp  (p_rp),
			.a        (a_w[e]),
			.b        (b_w[e]),
			.pa       (pa_w[e]),
			.pb       (pb_w[e]),
			.r        (r_w[e]),
			.rp       (rp_w[e])
		);
	end

	assign sum_w = a_w[L-1] + b_w[L-1];

	always_comb begin
		cand_valid = 1'b0;
		cand_kind  = KIND_SUM;
		cand_coef  = sum_w;
		cand_exp   = EXP_OUT_W'(L - 1) - EXP_OUT_W'(cnt_q);
		case (state_q)
			ST_SUM: begin
				// a slot present in both operands drops out when it cancels
				cand_valid = (pa_w[L-1] || pb_w[L-1])
					&& !(pa_w[L-1] && pb_w[L-1] && sum_w == '0);
			end
			ST_PROD: begin
				// chain output lags the broadcast by two steps
				cand_valid = (cnt_q >= CNT_W'(2)) && rp_w[L-1];
				cand_kind  = KIND_PROD;
				cand_coef  = r_w[L-1];
				cand_exp   = EXP_OUT_W'(2 * L) - EXP_OUT_W'(cnt_q);
			end
			default: begin
				cand_valid = 1'b0;
			end
		endcase
	end

	assign emit_hold = adv && cand_valid && hold_valid_q;
	assign emit_last = adv && !cand_valid && (state_q == ST_FLUSH) && hold_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			cnt_q          <= '0;
			hold_valid_q   <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept && last_term) begin
						state_q <= ST_SUM;
						cnt_q   <= '0;
					end
				end
				ST_SUM: begin
					if (step) begin
						if (cnt_q == CNT_W'(L - 1)) begin
							state_q <= ST_PROD;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				ST_PROD: begin
					if (step) begin
						if (cnt_q == CNT_W'(2 * L)) begin
							state_q <= ST_FLUSH;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (step) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase

			if (adv) begin
				result_valid_q <= emit_hold || emit_last;
				if (cand_valid) begin
					hold_valid_q <= 1'b1;
				end else if (emit_last) begin
					hold_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_hold || emit_last) begin
			kind_q    <= hold_kind_q;
			coef_q    <= OUT_COEF_W'(signed'(hold_coef_q));
			exp_q     <= hold_exp_q;
			run_end_q <= emit_last;
		end
		if (adv && cand_valid) begin
			hold_kind_q <= cand_kind;
			hold_coef_q <= cand_coef;
			hold_exp_q  <= cand_exp;
		end
	end

	assign result_valid = result_valid_q;
	assign result_kind  = kind_q;
	assign out_coef     = coef_q;
	assign out_exp      = exp_q;
	assign run_end      = run_end_q;

	`PAM_ASSERT_IMP(a_load_no_hold, state_q == ST_LOAD, !hold_valid_q, "held term while loading")
	`PAM_ASSERT_IMP(a_end_drains, result_valid_q && run_end_q, !hold_valid_q, "term held past run end")
	`PAM_ASSERT_NXT(a_stall_freeze, state_q == ST_PROD && !adv, $stable(cnt_q), "chain moved in stall")
	`PAM_ASSERT_IMP(a_flush_count, state_q == ST_FLUSH, cnt_q == CNT_W'(2 * L), "flush count off")

endmodule

`default_nettype wire
